@@ rtl/core/lfv_pkg.sv @@
package lfv_pkg;

	localparam int MAX_FRAME_BYTES = 10;
	localparam int CNT_W = 4;
	localparam int LEN_CAP = ((MAX_FRAME_BYTES + 1) > 15) ? 15 : (MAX_FRAME_BYTES + 1);

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_LENGTH   = 2'd1,
		ERR_PARITY   = 2'd2,
		ERR_CHECKSUM = 2'd3
	} lfv_err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} lfv_in_t;

	typedef struct packed {
		logic             frame_valid;
		logic [1:0]       error_kind;
		logic [CNT_W-1:0] frame_length;
		logic [7:0]       expected_checksum;
	} lfv_out_t;

	// 8-bit add with end-around carry
	function automatic logic [7:0] fold_add(input logic [7:0] s, input logic [7:0] b);
		logic [8:0] t;
		t = {1'b0, s} + {1'b0, b};
		return t[7:0] + {7'd0, t[8]};
	endfunction

	function automatic logic parity_good(input logic [7:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return (id[6] == p0) && (id[7] == p1);
	endfunction

endpackage

@@ rtl/core/lfv_in_stage.sv @@
module lfv_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  lfv_pkg::lfv_in_t item_word,
	input  logic            advance,
	output logic            valid_s1,
	output lfv_pkg::lfv_in_t item_s1
);

	logic accept;

	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_word;
		end
	end

endmodule

@@ rtl/core/lfv_frame_check.sv @@
module lfv_frame_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  lfv_pkg::lfv_in_t  item_s1,
	input  logic              checksum_enhanced,
	output lfv_pkg::lfv_out_t verdict
);

	logic [lfv_pkg::CNT_W-1:0] byte_count_q;
	logic [7:0]                running_sum_q;
	logic [7:0]                held_byte_q;
	logic                      id_parity_ok_q;

	logic [lfv_pkg::CNT_W-1:0] cnt_next;
	logic [7:0]                sum_next;
	logic                      par_next;
	logic                      first;
	logic                      skip_add;
	logic                      len_ok;
	logic [7:0]                expected;
	lfv_pkg::lfv_err_t         err;

	always_comb begin
		first    = (byte_count_q == '0);
		// classic mode leaves the ID byte out when it is folded in
		skip_add = first || (byte_count_q == lfv_pkg::CNT_W'(1) && !checksum_enhanced);
		par_next = first ? lfv_pkg::parity_good(item_s1.data_byte) : id_parity_ok_q;
		sum_next = skip_add ? running_sum_q : lfv_pkg::fold_add(running_sum_q, held_byte_q);
		cnt_next = (byte_count_q < lfv_pkg::CNT_W'(lfv_pkg::LEN_CAP)) ?
			byte_count_q + lfv_pkg::CNT_W'(1) : lfv_pkg::CNT_W'(lfv_pkg::LEN_CAP);
		expected = ~sum_next;
		len_ok   = (cnt_next == lfv_pkg::CNT_W'(1)) ||
			(cnt_next >= lfv_pkg::CNT_W'(3) &&
			 cnt_next <= lfv_pkg::CNT_W'(lfv_pkg::MAX_FRAME_BYTES));
		if (!len_ok) begin
			err = lfv_pkg::ERR_LENGTH;
		end else if (!par_next) begin
			err = lfv_pkg::ERR_PARITY;
		end else if (cnt_next > lfv_pkg::CNT_W'(1) && item_s1.data_byte != expected) begin
			err = lfv_pkg::ERR_CHECKSUM;
		end else begin
			err = lfv_pkg::ERR_NONE;
		end
		verdict.frame_valid       = (err == lfv_pkg::ERR_NONE);
		verdict.error_kind        = err;
		verdict.frame_length      = cnt_next;
		verdict.expected_checksum = expected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			running_sum_q  <= '0;
			held_byte_q    <= '0;
			id_parity_ok_q <= 1'b0;
		end else if (fire) begin
			if (item_s1.last_byte) begin
				// drop frame state for the next frame
				byte_count_q   <= '0;
				running_sum_q  <= '0;
				held_byte_q    <= '0;
				id_parity_ok_q <= 1'b0;
			end else begin
				byte_count_q   <= cnt_next;
				running_sum_q  <= sum_next;
				held_byte_q    <= item_s1.data_byte;
				id_parity_ok_q <= par_next;
			end
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= lfv_pkg::CNT_W'(lfv_pkg::LEN_CAP))
		else $error("byte count above cap");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.last_byte |=> byte_count_q == '0 && running_sum_q == '0)
		else $error("frame state not cleared after last word");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(byte_count_q) && $stable(running_sum_q))
		else $error("frame state moved without a word");

endmodule

@@ rtl/core/lfv_out_reg.sv @@
module lfv_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lfv_pkg::lfv_out_t verdict,
	output logic              out_free,
	output logic              result_valid,
	input  logic              result_stall,
	output lfv_pkg::lfv_out_t result_word
);

	logic valid_q;

	assign out_free     = !valid_q || !result_stall;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_word <= verdict;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("pending result overwritten");

endmodule

@@ rtl/core/lin_frame_validator_core.sv @@
// A word is held in the input register; a last word's verdict then waits in
// the result register. Throughput: one word per cycle unless item_stall; the
// two registers let a new word enter while a finished result waits downstream.
// Reset (arst_n low): all frame state clears, checksum_enhanced returns to 1,
// both valid flags drop.
module lin_frame_validator_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              checksum_enhanced_we,
	input  logic              checksum_enhanced_wdata,
	input  logic              item_valid,
	output logic              item_stall,
	input  lfv_pkg::lfv_in_t  item_word,
	output logic              result_valid,
	input  logic              result_stall,
	output lfv_pkg::lfv_out_t result_word
);

	logic              checksum_enhanced_q;
	logic              valid_s1;
	lfv_pkg::lfv_in_t  item_s1;
	logic              advance;
	logic              out_free;
	lfv_pkg::lfv_out_t verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_enhanced_q <= 1'b1;
		end else if (checksum_enhanced_we) begin
			checksum_enhanced_q <= checksum_enhanced_wdata;
		end
	end

	// a last word needs the result slot, others pass freely
	assign advance = valid_s1 && (!item_s1.last_byte || out_free);

	lfv_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_word  (item_word),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	lfv_frame_check u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.fire              (advance),
		.item_s1           (item_s1),
		.checksum_enhanced (checksum_enhanced_q),
		.verdict           (verdict)
	);

	lfv_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && item_s1.last_byte),
		.verdict      (verdict),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.last_byte && !out_free |-> item_stall)
		else $error("last word taken with result slot full");

endmodule

@@ verif/lin_frame_validator_core_tb.sv @@
module lin_frame_validator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASES = 8;
	localparam int PHASE_BYTES = 100;

	// Predicts frame verdicts byte by byte and holds the ones still owed by the block.
	class lin_verdict_tracker;
		bit enhanced;
		logic [3:0] count;
		logic [7:0] sum;
		logic [7:0] held;
		bit id_ok;
		lfv_pkg::lfv_out_t pending_verdicts[$];
		int errors;
		int checked;
		int by_kind[4];

		function new();
			enhanced = 1'b1;
			clear_frame();
		endfunction

		function void clear_frame();
			count = '0;
			sum = '0;
			held = '0;
			id_ok = 1'b0;
		endfunction

		// ones' complement add: wrap the carry back into bit 0
		static function logic [7:0] fold8(input logic [7:0] a, input logic [7:0] b);
			logic [8:0] t;
			t = {1'b0, a} + {1'b0, b};
			if (t[8])
				t = {1'b0, t[7:0]} + 9'd1;
			return t[7:0];
		endfunction

		static function logic [7:0] protect(input logic [5:0] id);
			logic p0;
			logic p1;
			p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
			p1 = !(id[1] ^ id[3] ^ id[4] ^ id[5]);
			return {p1, p0, id};
		endfunction

		function void absorb_byte(input lfv_pkg::lfv_in_t w);
			logic [3:0] prev;
			logic [7:0] inv_sum;
			lfv_pkg::lfv_err_t kind;
			lfv_pkg::lfv_out_t e;
			prev = count;
			if (prev == 4'd0)
				id_ok = (protect(w.data_byte[5:0]) == w.data_byte);
			else if (!(prev == 4'd1 && !enhanced))
				sum = fold8(sum, held);
			held = w.data_byte;
			count = (prev < lfv_pkg::LEN_CAP) ? prev + 4'd1 : 4'(lfv_pkg::LEN_CAP);
			if (!w.last_byte)
				return;
			inv_sum = ~sum;
			if (!(count == 4'd1 || (count >= 4'd3 && count <= lfv_pkg::MAX_FRAME_BYTES)))
				kind = lfv_pkg::ERR_LENGTH;
			else if (!id_ok)
				kind = lfv_pkg::ERR_PARITY;
			else if (count > 4'd1 && w.data_byte != inv_sum)
				kind = lfv_pkg::ERR_CHECKSUM;
			else
				kind = lfv_pkg::ERR_NONE;
			e.frame_valid = (kind == lfv_pkg::ERR_NONE);
			e.error_kind = kind;
			e.frame_length = count;
			e.expected_checksum = inv_sum;
			pending_verdicts.push_back(e);
			clear_frame();
		endfunction

		function void match_verdict(input lfv_pkg::lfv_out_t r);
			lfv_pkg::lfv_out_t e;
			if (pending_verdicts.size() == 0) begin
				$error("result word with no frame outstanding");
				errors++;
				return;
			end
			e = pending_verdicts.pop_front();
			checked++;
			by_kind[e.error_kind]++;
			if (r.frame_valid !== e.frame_valid) begin
				$error("frame_valid: expected %0d, got %0d", e.frame_valid, r.frame_valid);
				errors++;
			end
			if (r.error_kind !== e.error_kind) begin
				$error("error_kind: expected %0d, got %0d", e.error_kind, r.error_kind);
				errors++;
			end
			if (r.frame_length !== e.frame_length) begin
				$error("frame_length: expected %0d, got %0d", e.frame_length, r.frame_length);
				errors++;
			end
			if (r.expected_checksum !== e.expected_checksum) begin
				$error("expected_checksum: expected %0h, got %0h",
					e.expected_checksum, r.expected_checksum);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic checksum_enhanced_we = 1'b0;
	logic checksum_enhanced_wdata = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	lfv_pkg::lfv_in_t item_word = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	lfv_pkg::lfv_out_t result_word;

	lin_verdict_tracker verdicts = new();
	bit calm = 1'b0;
	int bytes_sent = 0;
	int cycle_count = 0;
	int stall_left = 0;
	int modes_used[2];

	lin_frame_validator_core dut (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.checksum_enhanced_we    (checksum_enhanced_we),
		.checksum_enhanced_wdata (checksum_enhanced_wdata),
		.item_valid              (item_valid),
		.item_stall              (item_stall),
		.item_word               (item_word),
		.result_valid            (result_valid),
		.result_stall            (result_stall),
		.result_word             (result_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// check the result word taken at this edge, then pick the next stall
	always @(posedge clk) begin
		int r;
		if (arst_n && result_valid && !result_stall)
			verdicts.match_verdict(result_word);
		if (calm) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				result_stall <= 1'b0;
			end else if (r < 95) begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(0, 3);
			end else begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(15, 60);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit last);
		int gap;
		int r;
		lfv_pkg::lfv_in_t w;
		r = $urandom_range(0, 99);
		gap = calm ? 0 : (r < 55) ? 0 :
			(r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		w.data_byte = b;
		w.last_byte = last;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_word <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		verdicts.absorb_byte(w);
		bytes_sent++;
	endtask

	// fill: 0 random payload, 1 all 0xff, 2 all 0x00
	task automatic send_frame(input logic [7:0] id, input int len, input int fill,
			input bit sum_ok);
		logic [7:0] body [0:15];
		logic [7:0] acc;
		int i;
		body[0] = id;
		acc = verdicts.enhanced ? id : 8'h00;
		for (i = 1; i < len; i++) begin
			body[i] = (fill == 1) ? 8'hff : (fill == 2) ? 8'h00 : 8'($urandom_range(0, 255));
			if (i < len - 1)
				acc = lin_verdict_tracker::fold8(acc, body[i]);
		end
		if (len >= 2)
			body[len - 1] = sum_ok ? ~acc : ~acc ^ 8'($urandom_range(1, 255));
		for (i = 0; i < len; i++)
			send_byte(body[i], i == len - 1);
	endtask

	// hold the sender until every verdict is back and the pipeline has drained
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (verdicts.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		checksum_enhanced_we <= 1'b1;
		checksum_enhanced_wdata <= m;
		@(posedge clk);
		checksum_enhanced_we <= 1'b0;
		verdicts.enhanced = m;
	endtask

	initial begin
		int p;
		int r;
		int n;
		int len;
		int start;
		bit m;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames in the reset mode (ID summed)
		send_frame(lin_verdict_tracker::protect(6'h00), 1, 0, 1'b1);
		send_frame(lin_verdict_tracker::protect(6'h3c) ^ 8'h40, 1, 0, 1'b1);
		send_frame(lin_verdict_tracker::protect(6'h15), 2, 0, 1'b1);
		send_frame(lin_verdict_tracker::protect(6'h3f), 3, 1, 1'b1);
		send_frame(lin_verdict_tracker::protect(6'h00), 3, 2, 1'b1);
		send_frame(lin_verdict_tracker::protect(6'h2a), 3, 0, 1'b0);
		// parity failure outranks the bad checksum
		send_frame(lin_verdict_tracker::protect(6'h11) ^ 8'h80, 3, 0, 1'b0);
		// overlong: count saturates, length error
		send_frame(lin_verdict_tracker::protect(6'h3f), 12, 1, 1'b1);
		modes_used[1]++;

		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			m = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
			write_mode(m);
			modes_used[m]++;
			calm = (p == 3);
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					n = $urandom_range(0, 99);
					len = (n < 5) ? 1 : (n < 10) ? 2 : (n < 90) ? $urandom_range(3, 10)
						: $urandom_range(11, 14);
					send_frame(($urandom_range(0, 9) != 0)
						? lin_verdict_tracker::protect(6'($urandom_range(0, 63)))
						: 8'($urandom_range(0, 255)),
						len, ($urandom_range(0, 19) == 0) ? 1 : 0,
						$urandom_range(0, 99) < 85);
				end else begin
					// junk bytes, closed with a last flag
					n = $urandom_range(1, 14);
					for (int i = 0; i < n; i++)
						send_byte(8'($urandom_range(0, 255)),
							(i == n - 1) || ($urandom_range(0, 3) == 0));
				end
			end
		end
		calm = 1'b0;

		wait_idle();
		repeat (10) @(posedge clk);
		if (verdicts.pending_verdicts.size() != 0) begin
			$error("%0d verdicts never arrived", verdicts.pending_verdicts.size());
			verdicts.errors++;
		end
		$display("Sent %0d bytes; checked %0d verdicts: %0d good, %0d length,",
			bytes_sent, verdicts.checked, verdicts.by_kind[lfv_pkg::ERR_NONE],
			verdicts.by_kind[lfv_pkg::ERR_LENGTH]);
		$display("%0d parity, %0d sum; mode phases: %0d classic, %0d enhanced",
			verdicts.by_kind[lfv_pkg::ERR_PARITY], verdicts.by_kind[lfv_pkg::ERR_CHECKSUM],
			modes_used[0], modes_used[1]);
		if (verdicts.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
